@@ rtl/core/sdss_pkg.sv @@
// ----------------------------------------------------------------------------
// sdss_pkg
// Types, segment codes and digit helpers for the signed decimal to
// seven-segment encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sdss_pkg;

    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    localparam logic signed [15:0] NUM_MAX = 16'sd9999;
    localparam logic signed [15:0] NUM_MIN = -16'sd999;
    localparam logic [13:0]        MAG_NEG_MAX = 14'd999;

    localparam logic [13:0] W_THOU = 14'd1000;
    localparam logic [13:0] W_HUND = 14'd100;
    localparam logic [13:0] W_TENS = 14'd10;

    localparam logic [2:0] PT_FIRST  = 3'd1;
    localparam logic [2:0] PT_SECOND = 3'd2;
    localparam logic [2:0] PT_THIRD  = 3'd3;
    localparam logic [2:0] PT_FOURTH = 3'd4;

    typedef struct packed {
        logic signed [15:0] number;
        logic [2:0]         point_position;
        logic               blank_leading;
    } sdss_in_t;

    typedef struct packed {
        logic [7:0] seg_first;
        logic [7:0] seg_second;
        logic [7:0] seg_third;
        logic [7:0] seg_fourth;
    } sdss_out_t;

    typedef struct packed {
        logic [2:0] point;
        logic       blank;
        logic       neg;
    } sdss_ctl_t;

    typedef struct packed {
        sdss_ctl_t   ctl;
        logic [13:0] mag;
    } sdss_s1_t;

    typedef struct packed {
        sdss_ctl_t  ctl;
        logic [3:0] d_thou;
        logic [9:0] rem;
    } sdss_s2_t;

    typedef struct packed {
        sdss_ctl_t  ctl;
        logic [3:0] d_thou;
        logic [3:0] d_hund;
        logic [6:0] rem;
    } sdss_s3_t;

    typedef struct packed {
        sdss_ctl_t  ctl;
        logic [3:0] d_thou;
        logic [3:0] d_hund;
        logic [3:0] d_tens;
        logic [3:0] d_unit;
    } sdss_s4_t;

    // quotient digit of value by weight, value below ten times weight
    function automatic logic [3:0] quot_digit(input logic [13:0] value,
                                              input logic [13:0] weight);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (value >= 14'(k) * weight) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    function automatic logic [13:0] dec_rem(input logic [13:0] value,
                                            input logic [3:0]  digit,
                                            input logic [13:0] weight);
        return value - 14'(digit) * weight;
    endfunction

    function automatic logic [7:0] seg_glyph(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h3F;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/signed_decimal_to_seven_segment.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_to_seven_segment
// Converts a signed value to four seven-segment bytes with minus sign,
// decimal point and optional leading-zero blanking.
// ----------------------------------------------------------------------------
// Five register stages: saturate and take the magnitude, thousands digit,
// hundreds digit, tens and units digits, segment encoding into the output
// register. A transaction is accepted every cycle while the output side
// keeps up, and its result moves through the stages in order. Each digit
// stage holds one bank of nine parallel compares against constant
// multiples and one subtract, which sets the clock limit. A stall holds
// every stage that cannot move; empty stages still fill.
`default_nettype none

module signed_decimal_to_seven_segment
    import sdss_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_valid,
    output logic      s_ready,
    input  sdss_in_t  s_data,
    output logic      m_valid,
    input  wire       m_ready,
    output sdss_out_t m_data
);

    localparam int NSTG = 5;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    sdss_s1_t  s1_reg, s1_next;
    sdss_s2_t  s2_reg, s2_next;
    sdss_s3_t  s3_reg, s3_next;
    sdss_s4_t  s4_reg, s4_next;
    sdss_out_t out_reg, out_next;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[NSTG-1];
    assign m_data  = out_reg;

    // stage 1: saturate, sign and magnitude
    always_comb begin
        logic signed [15:0] neg_val;
        neg_val                = -s_data.number;
        s1_next.ctl.point      = s_data.point_position;
        s1_next.ctl.blank      = s_data.blank_leading;
        s1_next.ctl.neg        = s_data.number[15];
        priority if (s_data.number > NUM_MAX) begin
            s1_next.mag = 14'(NUM_MAX);
        end else if (s_data.number < NUM_MIN) begin
            s1_next.mag = MAG_NEG_MAX;
        end else if (s_data.number[15]) begin
            s1_next.mag = neg_val[13:0];
        end else begin
            s1_next.mag = s_data.number[13:0];
        end
    end

    // stage 2: thousands
    always_comb begin
        logic [13:0] r;
        s2_next.ctl    = s1_reg.ctl;
        s2_next.d_thou = quot_digit(s1_reg.mag, W_THOU);
        r              = dec_rem(s1_reg.mag, s2_next.d_thou, W_THOU);
        s2_next.rem    = r[9:0];
    end

    // stage 3: hundreds
    always_comb begin
        logic [13:0] r;
        s3_next.ctl    = s2_reg.ctl;
        s3_next.d_thou = s2_reg.d_thou;
        s3_next.d_hund = quot_digit(14'(s2_reg.rem), W_HUND);
        r              = dec_rem(14'(s2_reg.rem), s3_next.d_hund, W_HUND);
        s3_next.rem    = r[6:0];
    end

    // stage 4: tens and units
    always_comb begin
        logic [13:0] r;
        s4_next.ctl    = s3_reg.ctl;
        s4_next.d_thou = s3_reg.d_thou;
        s4_next.d_hund = s3_reg.d_hund;
        s4_next.d_tens = quot_digit(14'(s3_reg.rem), W_TENS);
        r              = dec_rem(14'(s3_reg.rem), s4_next.d_tens, W_TENS);
        s4_next.d_unit = r[3:0];
    end

    // stage 5: blanking and segment encoding
    always_comb begin
        logic sup;
        logic p1, p2, p3, p4;
        p1  = s4_reg.ctl.point == PT_FIRST;
        p2  = s4_reg.ctl.point == PT_SECOND;
        p3  = s4_reg.ctl.point == PT_THIRD;
        p4  = s4_reg.ctl.point == PT_FOURTH;
        sup = s4_reg.ctl.blank;

        if (s4_reg.ctl.neg) begin
            out_next.seg_first = SEG_MINUS;
        end else if (s4_reg.d_thou == 4'd0 && !p1 && sup) begin
            out_next.seg_first = SEG_BLANK;
        end else begin
            out_next.seg_first = seg_glyph(s4_reg.d_thou);
            sup                = 1'b0;
        end
        if (p1) begin
            out_next.seg_first = out_next.seg_first | SEG_POINT;
        end

        if (s4_reg.d_hund == 4'd0 && !p2 && sup) begin
            out_next.seg_second = SEG_BLANK;
        end else begin
            out_next.seg_second = seg_glyph(s4_reg.d_hund);
            sup                 = 1'b0;
        end
        if (p2) begin
            out_next.seg_second = out_next.seg_second | SEG_POINT;
        end

        if (s4_reg.d_tens == 4'd0 && !p3 && sup) begin
            out_next.seg_third = SEG_BLANK;
        end else begin
            out_next.seg_third = seg_glyph(s4_reg.d_tens);
        end
        if (p3) begin
            out_next.seg_third = out_next.seg_third | SEG_POINT;
        end

        out_next.seg_fourth = seg_glyph(s4_reg.d_unit);
        if (p4) begin
            out_next.seg_fourth = out_next.seg_fourth | SEG_POINT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_reg <= s1_next;
        end
        if (adv[1]) begin
            s2_reg <= s2_next;
        end
        if (adv[2]) begin
            s3_reg <= s3_next;
        end
        if (adv[3]) begin
            s4_reg <= s4_next;
        end
        if (adv[4]) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sdss_checker.sv @@
// ----------------------------------------------------------------------------
// sdss_checker
// Port-level checks for the signed decimal to seven-segment encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module sdss_checker
    import sdss_pkg::*;
(
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input sdss_in_t  s_data,
    input wire       m_valid,
    input wire       m_ready,
    input sdss_out_t m_data
);

    // stalled transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // units digit is never blank
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.seg_fourth[6:0] != 7'd0)
        else $error("units digit blanked");

    // at most one decimal point
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_data.seg_first[7], m_data.seg_second[7],
                                m_data.seg_third[7], m_data.seg_fourth[7]}) <= 1)
        else $error("more than one decimal point");

endmodule

bind signed_decimal_to_seven_segment sdss_checker u_sdss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

@@ bench/sdss_segment_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdss_segment_checker
// Watches both channels of the seven-segment encoder. Every accepted input
// transaction is turned into its four expected segment bytes, which wait in
// order until the matching result transaction is accepted and compared byte
// by byte. Reports the number of failures and of results still outstanding.
// ----------------------------------------------------------------------------
module sdss_segment_checker
    import sdss_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_valid,
    input  wire       s_ready,
    input  sdss_in_t  s_data,
    input  wire       m_valid,
    input  wire       m_ready,
    input  sdss_out_t m_data,
    output int        error_count,
    output int        pending_count
);

    sdss_out_t expected_segments[$];
    sdss_out_t want;
    int        errors = 0;

    assign error_count = errors;

    function automatic logic [7:0] digit_glyph(input int d);
        logic [7:0] s;
        case (d)
            0:       s = 8'h3F;
            1:       s = 8'h06;
            2:       s = 8'h5B;
            3:       s = 8'h4F;
            4:       s = 8'h66;
            5:       s = 8'h6D;
            6:       s = 8'h7D;
            7:       s = 8'h07;
            8:       s = 8'h7F;
            default: s = 8'h6F;
        endcase
        return s;
    endfunction

    function automatic sdss_out_t segments_for(input sdss_in_t item);
        int         value;
        int         mag;
        int         first;
        int         digits[4];
        logic       hide;
        logic [7:0] seg[4];
        sdss_out_t  r;
        value = $signed(item.number);
        if (value > NUM_MAX) begin
            value = NUM_MAX;
        end
        if (value < NUM_MIN) begin
            value = NUM_MIN;
        end
        hide = item.blank_leading;
        if (value < 0) begin
            mag    = -value;
            seg[0] = SEG_MINUS;
            first  = 1;
        end else begin
            mag   = value;
            first = 0;
        end
        digits[0] = mag / 1000;
        digits[1] = (mag / 100) % 10;
        digits[2] = (mag / 10) % 10;
        digits[3] = mag % 10;
        for (int k = first; k < 3; k++) begin
            if (digits[k] == 0 && item.point_position != 3'(k + 1) && hide) begin
                seg[k] = SEG_BLANK;
            end else begin
                seg[k] = digit_glyph(digits[k]);
                hide   = 1'b0;
            end
        end
        seg[3] = digit_glyph(digits[3]);
        for (int k = 0; k < 4; k++) begin
            if (item.point_position == 3'(k + 1)) begin
                seg[k] = seg[k] | SEG_POINT;
            end
        end
        r.seg_first  = seg[0];
        r.seg_second = seg[1];
        r.seg_third  = seg[2];
        r.seg_fourth = seg[3];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            errors++;
            $display("%0t: %s expected %02h, actual %02h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_segments.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_segments.size() == 0) begin
                    errors++;
                    $display("%0t: result transaction %08h expected none, actual %08h",
                             $time, m_data, m_data);
                end else begin
                    want = expected_segments.pop_front();
                    check_field("seg_first", want.seg_first, m_data.seg_first);
                    check_field("seg_second", want.seg_second, m_data.seg_second);
                    check_field("seg_third", want.seg_third, m_data.seg_third);
                    check_field("seg_fourth", want.seg_fourth, m_data.seg_fourth);
                end
            end
            if (s_valid && s_ready) begin
                expected_segments.push_back(segments_for(s_data));
            end
        end
        pending_count <= expected_segments.size();
    end

endmodule

@@ bench/tb_signed_decimal_to_seven_segment.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_decimal_to_seven_segment
// Drives the encoder with directed corner values and then random numbers,
// decimal point selectors and blanking flags under three idling patterns
// on both channels. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module tb_signed_decimal_to_seven_segment;
    import sdss_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 230;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sdss_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sdss_out_t m_data;

    int error_count;
    int pending_count;
    int send_idle_pct = 18;
    int recv_idle_pct = 46;
    int quiet_cycles  = 0;

    signed_decimal_to_seven_segment i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sdss_segment_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic sdss_in_t make_item(input int num, input int pt, input bit blank);
        sdss_in_t item;
        item.number         = 16'(num);
        item.point_position = 3'(pt);
        item.blank_leading  = blank;
        return item;
    endfunction

    function automatic sdss_in_t random_item();
        int sel;
        int num;
        sel = int'($urandom_range(0, 9));
        if (sel < 4) begin
            num = int'($urandom_range(0, 65535));
        end else if (sel < 8) begin
            num = int'($urandom_range(0, 10998)) - 999;
        end else begin
            num = int'($urandom_range(0, 40)) - 20;
        end
        return make_item(num, int'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_item(input sdss_in_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner values, point selectors and blanking cases
        send_item(make_item(0, 0, 1'b0));
        send_item(make_item(0, 0, 1'b1));
        send_item(make_item(9999, 4, 1'b0));
        send_item(make_item(10000, 0, 1'b1));
        send_item(make_item(32767, 1, 1'b0));
        send_item(make_item(-32768, 0, 1'b0));
        send_item(make_item(-999, 1, 1'b1));
        send_item(make_item(-1000, 2, 1'b0));
        send_item(make_item(-1, 0, 1'b1));
        send_item(make_item(-5, 3, 1'b1));
        send_item(make_item(-50, 0, 1'b1));
        send_item(make_item(-7, 2, 1'b1));
        send_item(make_item(5, 2, 1'b1));
        send_item(make_item(5, 1, 1'b1));
        send_item(make_item(7, 3, 1'b1));
        send_item(make_item(1234, 3, 1'b1));
        send_item(make_item(8, 5, 1'b1));
        send_item(make_item(9, 6, 1'b0));
        send_item(make_item(42, 7, 1'b1));
        send_item(make_item(100, 0, 1'b1));
        send_item(make_item(1000, 0, 1'b0));
        send_item(make_item(32767, 7, 1'b1));
        send_item(make_item(-1, 7, 1'b1));

        for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_item(random_item());
        end

        send_idle_pct = 46;
        recv_idle_pct = 18;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) begin
                drain_results();
            end
            send_item(random_item());
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_item(random_item());
        end

        drain_results();
        repeat (20) @(posedge aclk);

        if (error_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
